/* hdl/lpip_pkg.sv */
// Package for the length-prefixed instruction parser.
// Holds the parse phases, verdict codes, the result record and the opcode name table.
// No dependencies.
`timescale 1ns / 1ps

package lpip_pkg;

    localparam int OPCODE_COUNT = 11;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        PH_DIGITS  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_TERM    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PARSE_ERR = 2'd1,
        ST_UNKNOWN   = 2'd2
    } status_t;

    localparam logic KIND_ARG     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;

    typedef struct packed {
        logic       kind;
        logic [7:0] arg_byte;
        logic [7:0] arg_index;
        logic [1:0] status;
        logic [3:0] opcode_index;
        logic [7:0] arg_count;
    } rec_t;

    // Names are left-aligned: the first character sits in the top byte.
    localparam logic [63:0] OP_NAME [OPCODE_COUNT] = '{
        {"mouse",   24'h0},
        {"key",     40'h0},
        {"rename",  16'h0},
        {"connect",  8'h0},
        {"chat",    32'h0},
        {"turn",    32'h0},
        {"admin",   24'h0},
        {"nop",     40'h0},
        {"list",    32'h0},
        {"vote",    32'h0},
        {"file",    32'h0}
    };

    localparam logic [3:0] OP_LEN [OPCODE_COUNT] = '{
        4'd5, 4'd3, 4'd6, 4'd7, 4'd4, 4'd4, 4'd5, 4'd3, 4'd4, 4'd4, 4'd4
    };

endpackage

/* hdl/lpip_front.sv */
// Front end of the parser: takes bytes, tracks the element structure and matches the opcode.
// Produces argument byte and verdict requests for the queue. Depends on lpip_pkg.
`timescale 1ns / 1ps

module lpip_front #(
    parameter int MAX_ELEMENT_LEN = 65535,
    parameter int MAX_ARGS        = 255
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        byte_in,
    input  logic              last_byte,
    input  logic              accept,
    output logic              push,
    output lpip_pkg::rec_t    push_rec
);

    lpip_pkg::phase_t                    phase_reg, phase_next;
    logic [15:0]                         acc_reg, acc_next;
    logic [15:0]                         left_reg, left_next;
    logic [7:0]                          cnt_reg, cnt_next;
    logic [lpip_pkg::OPCODE_COUNT-1:0]   cand_reg, cand_next;
    logic [3:0]                          pos_reg, pos_next;
    logic                                err_reg, err_next;
    logic                                opdone_reg, opdone_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lpip_pkg::PH_DIGITS;
            acc_reg    <= '0;
            left_reg   <= '0;
            cnt_reg    <= '0;
            cand_reg   <= '1;
            pos_reg    <= '0;
            err_reg    <= 1'b0;
            opdone_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg  <= lpip_pkg::PH_DIGITS;
                acc_reg    <= '0;
                left_reg   <= '0;
                cnt_reg    <= '0;
                cand_reg   <= '1;
                pos_reg    <= '0;
                err_reg    <= 1'b0;
                opdone_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                left_reg   <= left_next;
                cnt_reg    <= cnt_next;
                cand_reg   <= cand_next;
                pos_reg    <= pos_next;
                err_reg    <= err_next;
                opdone_reg <= opdone_next;
            end
        end
    end

    logic [19:0]                         acc_ext;
    logic [lpip_pkg::OPCODE_COUNT-1:0]   cand_end;
    logic                                finished;
    logic                                emit;
    logic [3:0]                          op_sel;
    logic [7:0]                          name_ch;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        cnt_next    = cnt_reg;
        cand_next   = cand_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        opdone_next = opdone_reg;
        finished    = 1'b0;
        emit        = 1'b0;
        acc_ext     = '0;
        cand_end    = cand_reg;
        op_sel      = '0;
        name_ch     = '0;
        push_rec    = '0;

        if (!err_reg)
        begin
            unique case (phase_reg)
                lpip_pkg::PH_DIGITS:
                begin
                    if (byte_in >= lpip_pkg::CH_ZERO && byte_in <= lpip_pkg::CH_NINE)
                    begin
                        acc_ext = 20'(acc_reg) * 20'd10 + 20'(byte_in - lpip_pkg::CH_ZERO);
                        if (acc_ext > 20'(MAX_ELEMENT_LEN))
                            err_next = 1'b1;
                        else
                            acc_next = acc_ext[15:0];
                    end
                    else if (byte_in == lpip_pkg::CH_DOT)
                    begin
                        left_next  = acc_reg;
                        acc_next   = '0;
                        phase_next = (acc_reg != '0) ? lpip_pkg::PH_CONTENT
                                                     : lpip_pkg::PH_TERM;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                lpip_pkg::PH_CONTENT:
                begin
                    if (!opdone_reg)
                    begin
                        for (int i = 0; i < lpip_pkg::OPCODE_COUNT; i++)
                        begin
                            name_ch = lpip_pkg::OP_NAME[i][63 - 8*pos_reg[2:0] -: 8];
                            if (pos_reg >= lpip_pkg::OP_LEN[i] || name_ch != byte_in)
                                cand_next[i] = 1'b0;
                        end
                        if (pos_reg != 4'd15)
                            pos_next = pos_reg + 4'd1;
                    end
                    else if (!last_byte)
                    begin
                        emit = 1'b1;
                    end
                    left_next = left_reg - 16'd1;
                    if (left_next == '0)
                        phase_next = lpip_pkg::PH_TERM;
                end
                lpip_pkg::PH_TERM:
                begin
                    if (byte_in == lpip_pkg::CH_COMMA || byte_in == lpip_pkg::CH_SEMI)
                    begin
                        if (!opdone_reg)
                        begin
                            for (int i = 0; i < lpip_pkg::OPCODE_COUNT; i++)
                            begin
                                if (lpip_pkg::OP_LEN[i] != pos_reg)
                                    cand_end[i] = 1'b0;
                            end
                            cand_next   = cand_end;
                            opdone_next = 1'b1;
                            if (cand_end == '0)
                                err_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 8'd1;
                        end
                        if (!err_next)
                        begin
                            if (byte_in == lpip_pkg::CH_SEMI)
                            begin
                                if (last_byte)
                                    finished = 1'b1;
                                else
                                    err_next = 1'b1;
                            end
                            else if (last_byte || cnt_next >= 8'(MAX_ARGS))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = lpip_pkg::PH_DIGITS;
                                acc_next   = '0;
                            end
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = lpip_pkg::PH_DIGITS;
                end
            endcase
        end

        for (int i = lpip_pkg::OPCODE_COUNT - 1; i >= 0; i--)
        begin
            if (cand_next[i])
                op_sel = 4'(i);
        end

        if (last_byte)
        begin
            push_rec.kind      = lpip_pkg::KIND_VERDICT;
            push_rec.arg_count = cnt_next;
            if (opdone_next && cand_next == '0)
                push_rec.status = lpip_pkg::ST_UNKNOWN;
            else if (err_next || !finished)
                push_rec.status = lpip_pkg::ST_PARSE_ERR;
            else
            begin
                push_rec.status       = lpip_pkg::ST_OK;
                push_rec.opcode_index = op_sel;
            end
        end
        else
        begin
            push_rec.kind      = lpip_pkg::KIND_ARG;
            push_rec.arg_byte  = byte_in;
            push_rec.arg_index = cnt_reg;
        end
    end

    assign push = accept && (emit || last_byte);

endmodule

/* hdl/lpip_queue.sv */
// Short queue of result requests between the parser front end and the output stage.
// Depends on lpip_pkg.
`timescale 1ns / 1ps

module lpip_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lpip_pkg::rec_t    push_rec,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output lpip_pkg::rec_t    head_rec
);

    localparam int PTR_W = $clog2(lpip_pkg::QUEUE_DEPTH);

    lpip_pkg::rec_t     slot_reg [lpip_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(lpip_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(lpip_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assign full      = (count_reg == (PTR_W+1)'(lpip_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_rec  = slot_reg[rd_ptr_reg];

endmodule

/* hdl/lpip_back.sv */
// Output stage: takes requests from the queue into a registered result port.
// Depends on lpip_pkg.
`timescale 1ns / 1ps

module lpip_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  lpip_pkg::rec_t    q_rec,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output lpip_pkg::rec_t    out_rec
);

    logic             valid_reg;
    lpip_pkg::rec_t   rec_reg;

    assign pop = q_valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= q_rec;
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

/* hdl/length_prefixed_instruction_parser_top.sv */
// Top level of the length-prefixed instruction parser.
// Instantiates lpip_front, lpip_queue and lpip_back; depends on lpip_pkg.
//
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_ready   byte_in, last_byte
// output   out        out_valid / out_ready kind, arg_byte, arg_index, status,
//                                           opcode_index, arg_count
//
// One byte is taken every clock while in_ready is high; the parser front end decides each byte combinationally.
// A result passes from its byte through the queue and then the output register.
// Reset is asynchronous and active low, and leaves the parser waiting for a length digit.
// A stalled output fills the two-entry queue, and only then is in_ready dropped.
`timescale 1ns / 1ps

module length_prefixed_instruction_parser_top #(
    parameter int MAX_ELEMENT_LEN = 65535,
    parameter int MAX_ARGS        = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  arg_byte,
    output logic [7:0]  arg_index,
    output logic [1:0]  status,
    output logic [3:0]  opcode_index,
    output logic [7:0]  arg_count
);

    logic             accept;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_not_empty;
    lpip_pkg::rec_t   push_rec;
    lpip_pkg::rec_t   head_rec;
    lpip_pkg::rec_t   out_rec;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    lpip_front #(
        .MAX_ELEMENT_LEN (MAX_ELEMENT_LEN),
        .MAX_ARGS        (MAX_ARGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .last_byte (last_byte),
        .accept    (accept),
        .push      (q_push),
        .push_rec  (push_rec)
    );

    lpip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (push_rec),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_rec  (head_rec)
    );

    lpip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_rec     (head_rec),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rec   (out_rec)
    );

    assign kind         = out_rec.kind;
    assign arg_byte     = out_rec.arg_byte;
    assign arg_index    = out_rec.arg_index;
    assign status       = out_rec.status;
    assign opcode_index = out_rec.opcode_index;
    assign arg_count    = out_rec.arg_count;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("Request written into a full queue.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("Request taken from an empty queue.");

    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == lpip_pkg::KIND_VERDICT) |->
            (arg_byte == 8'd0 && arg_index == 8'd0 && status != 2'd3))
        else $error("Verdict carries argument data or an invalid status.");

    a_opcode_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != lpip_pkg::ST_OK) |-> (opcode_index == 4'd0))
        else $error("Opcode index given with a failing status.");

    a_arg_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == lpip_pkg::KIND_ARG) |->
            (status == lpip_pkg::ST_OK && opcode_index == 4'd0 && arg_count == 8'd0))
        else $error("Argument byte carries verdict fields.");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for length_prefixed_instruction_parser_top.
// Streams directed and random instructions, predicts every argument byte and verdict in a
// scoreboard class, and checks the results in order; depends on lpip_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_LEN     = 65535;
    localparam int MAX_ARG_NUM = 255;
    localparam int STALL_LIMIT = 1000;
    localparam int TOTAL_BYTES = 1200;

    class instr_checker;

        lpip_pkg::rec_t                    expected_q[$];
        int                                errors;
        int                                max_len;
        int                                max_args;
        lpip_pkg::phase_t                  ph;
        logic [15:0]                       len_acc;
        logic [15:0]                       remaining;
        logic [7:0]                        n_args;
        logic [lpip_pkg::OPCODE_COUNT-1:0] cand;
        logic [3:0]                        npos;
        bit                                err;
        bit                                op_seen;

        function new(int len_limit, int arg_limit);
            max_len  = len_limit;
            max_args = arg_limit;
            errors   = 0;
            clear();
        endfunction

        function void clear();
            ph        = lpip_pkg::PH_DIGITS;
            len_acc   = '0;
            remaining = '0;
            n_args    = '0;
            cand      = '1;
            npos      = '0;
            err       = 1'b0;
            op_seen   = 1'b0;
        endfunction

        function void match_char(logic [7:0] b);
            int p;
            p = npos & 7;
            for (int i = 0; i < lpip_pkg::OPCODE_COUNT; i++)
            begin
                if (npos >= lpip_pkg::OP_LEN[i] || lpip_pkg::OP_NAME[i][63 - 8 * p -: 8] != b)
                    cand[i] = 1'b0;
            end
            if (npos < 4'd15)
                npos++;
        endfunction

        function void note_request(logic [7:0] b, logic last);
            int unsigned         v;
            bit                  done;
            lpip_pkg::rec_t      r;
            lpip_pkg::status_t   st;
            logic [3:0]          op;
            done = 1'b0;
            if (!err)
            begin
                unique case (ph)
                    lpip_pkg::PH_DIGITS:
                    begin
                        if (b >= lpip_pkg::CH_ZERO && b <= lpip_pkg::CH_NINE)
                        begin
                            v = len_acc * 10 + (b - lpip_pkg::CH_ZERO);
                            if (v > max_len)
                                err = 1'b1;
                            else
                                len_acc = v[15:0];
                        end
                        else if (b == lpip_pkg::CH_DOT)
                        begin
                            remaining = len_acc;
                            len_acc   = '0;
                            ph        = (remaining != 0) ? lpip_pkg::PH_CONTENT
                                                         : lpip_pkg::PH_TERM;
                        end
                        else
                            err = 1'b1;
                    end
                    lpip_pkg::PH_CONTENT:
                    begin
                        if (!op_seen)
                            match_char(b);
                        else if (!last)
                        begin
                            r           = '0;
                            r.kind      = lpip_pkg::KIND_ARG;
                            r.arg_byte  = b;
                            r.arg_index = n_args;
                            expected_q.insert(expected_q.size(), r);
                        end
                        remaining--;
                        if (remaining == 0)
                            ph = lpip_pkg::PH_TERM;
                    end
                    default:
                    begin
                        if (b == lpip_pkg::CH_COMMA || b == lpip_pkg::CH_SEMI)
                        begin
                            if (!op_seen)
                            begin
                                for (int i = 0; i < lpip_pkg::OPCODE_COUNT; i++)
                                begin
                                    if (lpip_pkg::OP_LEN[i] != npos)
                                        cand[i] = 1'b0;
                                end
                                op_seen = 1'b1;
                                if (cand == 0)
                                    err = 1'b1;
                            end
                            else
                                n_args++;
                            if (!err)
                            begin
                                if (b == lpip_pkg::CH_SEMI)
                                begin
                                    if (last)
                                        done = 1'b1;
                                    else
                                        err = 1'b1;
                                end
                                else if (last || n_args >= max_args)
                                    err = 1'b1;
                                else
                                begin
                                    ph      = lpip_pkg::PH_DIGITS;
                                    len_acc = '0;
                                end
                            end
                        end
                        else
                            err = 1'b1;
                    end
                endcase
            end
            if (last)
            begin
                op = '0;
                if (op_seen && cand == 0)
                    st = lpip_pkg::ST_UNKNOWN;
                else if (err || !done)
                    st = lpip_pkg::ST_PARSE_ERR;
                else
                begin
                    st = lpip_pkg::ST_OK;
                    for (int i = lpip_pkg::OPCODE_COUNT - 1; i >= 0; i--)
                    begin
                        if (cand[i])
                            op = 4'(i);
                    end
                end
                r              = '0;
                r.kind         = lpip_pkg::KIND_VERDICT;
                r.status       = st;
                r.opcode_index = op;
                r.arg_count    = n_args;
                expected_q.insert(expected_q.size(), r);
                clear();
            end
        endfunction

        function void compare_field(string fname, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                $error("%s: expected %0h, actual %0h", fname, want, seen);
                errors++;
            end
        endfunction

        function void check_result(lpip_pkg::rec_t got);
            lpip_pkg::rec_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: kind %0d arg_byte %0h status %0d",
                       got.kind, got.arg_byte, got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("arg_byte", want.arg_byte, got.arg_byte);
            compare_field("arg_index", want.arg_index, got.arg_index);
            compare_field("status", want.status, got.status);
            compare_field("opcode_index", want.opcode_index, got.opcode_index);
            compare_field("arg_count", want.arg_count, got.arg_count);
        endfunction

    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  arg_byte;
    logic [7:0]  arg_index;
    logic [1:0]  status;
    logic [3:0]  opcode_index;
    logic [7:0]  arg_count;

    instr_checker board;
    logic [7:0]   txt[$];
    int           burst_left = 0;
    int           bytes_sent = 0;
    int           idle_cycles = 0;
    bit           stim_done = 1'b0;
    logic [9:0]   ready_phase = '0;

    string opcode_text[lpip_pkg::OPCODE_COUNT] = '{
        "mouse", "key", "rename", "connect", "chat", "turn",
        "admin", "nop", "list", "vote", "file"
    };

    length_prefixed_instruction_parser_top #(
        .MAX_ELEMENT_LEN(MAX_LEN),
        .MAX_ARGS(MAX_ARG_NUM)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .byte_in(byte_in),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .arg_byte(arg_byte),
        .arg_index(arg_index),
        .status(status),
        .opcode_index(opcode_index),
        .arg_count(arg_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        ready_phase <= ready_phase + 1'b1;
        case (ready_phase[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= (ready_phase[2:0] != 3'd0);
            default: out_ready <= (ready_phase[3:0] < 4'd3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({kind, arg_byte, arg_index, status, opcode_index, arg_count});
    end

    always @(posedge clk)
    begin
        if (rst_n && (!stim_done || board.expected_q.size() != 0))
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("length_prefixed_instruction_parser_top: mismatch");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        byte_in   <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_instr();
        for (int i = 0; i < txt.size(); i++)
            send_byte(txt[i], i == txt.size() - 1);
        txt.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            txt.insert(txt.size(), s[i]);
    endtask

    task automatic put_length(input int n, input bit odd_form);
        if (!(odd_form && n == 0))
        begin
            if (odd_form)
                put_text("00");
            put_text($sformatf("%0d", n));
        end
        txt.insert(txt.size(), lpip_pkg::CH_DOT);
    endtask

    function automatic string pick_opcode();
        int    k;
        int    n;
        string s;
        k = $urandom_range(0, 99);
        s = opcode_text[$urandom_range(0, lpip_pkg::OPCODE_COUNT - 1)];
        if (k < 80)
            return s;
        if (k < 90)
            return ($urandom_range(0, 1) == 0) ? s.substr(0, s.len() - 2) : {s, "s"};
        s = "";
        n = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
            s = {s, string'(8'($urandom_range(8'h61, 8'h7a)))};
        return s;
    endfunction

    task automatic build_random_instr();
        int    pick;
        int    nargs;
        int    alen;
        int    declared;
        int    cut;
        string name;
        string charset;
        charset = "0123456789.,;";
        pick = $urandom_range(0, 99);
        if (pick >= 97)
        begin
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 1) == 0)
                    txt.insert(txt.size(), charset[$urandom_range(0, 12)]);
                else
                    txt.insert(txt.size(), 8'($urandom_range(0, 255)));
            end
            return;
        end
        name = pick_opcode();
        put_length(name.len(), $urandom_range(0, 9) == 0);
        put_text(name);
        nargs = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
        if (pick >= 93 && nargs == 0)
            nargs = 1;
        for (int a = 0; a < nargs; a++)
        begin
            txt.insert(txt.size(), lpip_pkg::CH_COMMA);
            alen = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
            declared = alen;
            if (pick >= 93 && a == 0)
            begin
                case ($urandom_range(0, 4))
                    0: declared = MAX_LEN + 1 + $urandom_range(0, 1000);
                    1, 2: declared = alen + 1;
                    default: declared = (alen > 0) ? alen - 1 : alen + 2;
                endcase
            end
            put_length(declared, $urandom_range(0, 9) == 0);
            repeat (alen) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end
        txt.insert(txt.size(), lpip_pkg::CH_SEMI);
        if (pick >= 70 && pick < 85)
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        else if (pick >= 85 && pick < 89)
        begin
            cut = $urandom_range(1, txt.size());
            while (txt.size() > cut)
                void'(txt.pop_back());
        end
        else if (pick >= 89 && pick < 93)
        begin
            repeat ($urandom_range(1, 4)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        board = new(MAX_LEN, MAX_ARG_NUM);
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < lpip_pkg::OPCODE_COUNT; i++)
        begin
            put_length(opcode_text[i].len(), 1'b0);
            put_text(opcode_text[i]);
            repeat (i % 3) put_text(",1.q");
            put_text(";");
            send_instr();
        end
        put_text("4.chat,2.hi,3.abc;");
        send_instr();
        put_text("3.nop,4.");
        txt.insert(txt.size(), 8'hff);
        txt.insert(txt.size(), 8'h00);
        txt.insert(txt.size(), 8'h80);
        txt.insert(txt.size(), 8'h7f);
        put_text(";");
        send_instr();
        put_text("0.;");
        send_instr();
        put_text("3.foo,1.x;");
        send_instr();
        put_text("65536.x;");
        send_instr();
        put_text("3.nop,65535.xy");
        send_instr();
        put_text("3.nop,2.ab;x");
        send_instr();
        put_text("3.nop,2.ab,");
        send_instr();
        put_text("3x.nop;");
        send_instr();
        put_text("3.nop:");
        send_instr();
        put_text("8.connectx;");
        send_instr();
        put_text("16.abcdefghijklmnop;");
        send_instr();
        put_text("3.key,.,2.ab;");
        send_instr();
        put_text("0003.key;");
        send_instr();
        put_text(";");
        send_instr();
        put_text("3.nop");
        repeat (MAX_ARG_NUM) put_text(",.");
        put_text(",.;");
        send_instr();

        while (bytes_sent < TOTAL_BYTES)
        begin
            build_random_instr();
            send_instr();
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;

        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("length_prefixed_instruction_parser_top: match");
        else
            $display("length_prefixed_instruction_parser_top: mismatch");
        $finish;
    end

endmodule

/* files.f */
hdl/lpip_pkg.sv
hdl/lpip_front.sv
hdl/lpip_queue.sv
hdl/lpip_back.sv
hdl/length_prefixed_instruction_parser_top.sv
verif/tb_top.sv
